// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on aclk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RSM_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RSM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/rsm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range shuffle sampler package
// Field widths, item codes and shared types of the sampler.
// ----------------------------------------------------------------------------
package rsm_pkg;

    localparam int IDX_W      = 10;
    localparam int SIZE_W     = 11;
    localparam int WORD_W     = 15;
    localparam int MODE_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int IDX_SPAN   = 1 << IDX_W;

    localparam int DVD_W = WORD_W;
    localparam int DIV_W = IDX_W;

    localparam logic [IDX_W-1:0] EDGE_MAX = 10'd999;

    localparam logic [MODE_W-1:0] MODE_START   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SHUFFLE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ    = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ILLEGAL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SEQ     = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_LEFT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE  = 2'd2;

    typedef struct packed {
        logic busy;
        logic done;
    } rem_stat_t;

endpackage

// ===== design/rsm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rsm_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/rsm_rem.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// Remainder unit
// Restoring remainder, one dividend bit per cycle, with a done pulse.
// ----------------------------------------------------------------------------
module rsm_rem (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [rsm_pkg::DVD_W-1:0] dividend,
    input  logic [rsm_pkg::DIV_W-1:0] divisor,
    output rsm_pkg::rem_stat_t        stat,
    output logic [rsm_pkg::DIV_W-1:0] rem
);
    import rsm_pkg::*;

    localparam int CNT_W = $clog2(DVD_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DVD_W - 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [DIV_W-1:0] div_reg, div_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W:0]   trial;

    always_comb begin
        trial     = {rem_reg, dvd_reg[DVD_W-1]};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            div_next  = divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            if (trial >= {1'b0, div_reg}) begin
                rem_next = DIV_W'(trial - {1'b0, div_reg});
            end else begin
                rem_next = DIV_W'(trial);
            end
            dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign rem       = rem_reg;

    `RSM_ASSERT_IMPLY(a_no_restart, start, !busy_reg, "remainder unit restarted while busy")
    `RSM_ASSERT_IMPLY(a_rem_below_div, busy_reg, rem_reg < div_reg, "partial remainder too large")

endmodule

// ===== design/range_shuffle_sampler_core.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// Range shuffle sampler core
// Swap shuffle over a stored index table with sample read-out.
// ----------------------------------------------------------------------------
// The block handles one item at a time and holds s_tready low while it works.
// A shuffle item reduces the random word modulo right - left in the shared
// remainder unit, then swaps two table entries through the single read port
// of the table memory. A read item fetches one entry, and a start item
// rewrites the table to identity over the configured range, one entry a
// cycle. With TABLE_SIZE below 1024 each table index is reduced by a further
// pass through the remainder unit (two per shuffle, one per read or start).
// The table is not cleared after reset; a start item must come first.
module range_shuffle_sampler_core #(
    parameter int TABLE_SIZE = 1024
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [14:0] random_word, [15] zero
    input  logic [rsm_pkg::S_TDATA_W-1:0]  s_tdata,
    // [1:0] mode
    input  logic [rsm_pkg::MODE_W-1:0]     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [9:0] sample_value, [15:10] zero
    output logic [rsm_pkg::M_TDATA_W-1:0]  m_tdata,
    // [1:0] status
    output logic [rsm_pkg::STATUS_W-1:0]   m_tuser,
    output logic                           m_tlast,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rsm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rsm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rsm_pkg::*;

    localparam int AW = $clog2(TABLE_SIZE);
    localparam bit NEED_WRAP = (TABLE_SIZE < IDX_SPAN);
    localparam logic [DIV_W-1:0] TBL_DIV = DIV_W'(TABLE_SIZE);
    localparam logic [AW-1:0] ADDR_LAST = AW'(TABLE_SIZE - 1);

    typedef enum logic [1:0] {PH_IDLE, PH_SHUF, PH_READ, PH_DONE} phase_t;

    typedef enum logic [3:0] {
        S_IDLE, S_CLRB, S_CLEAR, S_MOD, S_ADDR, S_WRPA, S_WRPB, S_RDA,
        S_RDB, S_WRA, S_WRB, S_RIDX, S_RWRP, S_RDQ, S_RDD, S_EMIT
    } state_t;

    state_t              st_reg, st_next;
    phase_t              phase_reg, phase_next;
    logic [IDX_W-1:0]    left_reg, left_next;
    logic [IDX_W-1:0]    right_reg, right_next;
    logic [SIZE_W-1:0]   size_reg, size_next;
    logic [IDX_W-1:0]    pos_reg, pos_next;
    logic [SIZE_W-1:0]   rcnt_reg, rcnt_next;
    logic [IDX_W-1:0]    target_reg, target_next;
    logic [AW-1:0]       a_reg, a_next;
    logic [AW-1:0]       b_reg, b_next;
    logic [IDX_W-1:0]    va_reg, va_next;
    logic [AW-1:0]       clr_addr_reg, clr_addr_next;
    logic [SIZE_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [IDX_W-1:0]    res_value_reg, res_value_next;
    logic                res_last_reg, res_last_next;
    logic                m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0] m_status_reg, m_status_next;
    logic [IDX_W-1:0]    m_value_reg, m_value_next;
    logic                m_last_reg, m_last_next;

    logic                rem_start;
    logic [DVD_W-1:0]    rem_dvd;
    logic [DIV_W-1:0]    rem_div;
    rem_stat_t           rem_stat;
    logic [DIV_W-1:0]    rem_val;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [IDX_W-1:0]    ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [IDX_W-1:0]    ram_rdata;

    logic [SIZE_W-1:0]   span1;
    logic                legal;
    logic [SIZE_W-1:0]   rcnt_inc;

    rsm_rem u_rem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (rem_start),
        .dividend (rem_dvd),
        .divisor  (rem_div),
        .stat     (rem_stat),
        .rem      (rem_val)
    );

    rsm_ram #(
        .WIDTH (IDX_W),
        .DEPTH (TABLE_SIZE)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cfg_ready = (st_reg == S_IDLE);
    assign s_tready  = (st_reg == S_IDLE) && !cfg_valid;

    always_comb begin
        span1 = {1'b0, right_reg} - {1'b0, left_reg} + 1'b1;
        legal = (left_reg <= EDGE_MAX) && (right_reg <= EDGE_MAX) &&
                (right_reg >= left_reg) && (left_reg != '0) && (size_reg <= span1);
        rcnt_inc = rcnt_reg + 1'b1;

        st_next         = st_reg;
        phase_next      = phase_reg;
        left_next       = left_reg;
        right_next      = right_reg;
        size_next       = size_reg;
        pos_next        = pos_reg;
        rcnt_next       = rcnt_reg;
        target_next     = target_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        va_next         = va_reg;
        clr_addr_next   = clr_addr_reg;
        clr_cnt_next    = clr_cnt_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        res_last_next   = res_last_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_status_next   = m_status_reg;
        m_value_next    = m_value_reg;
        m_last_next     = m_last_reg;

        rem_start = 1'b0;
        rem_dvd   = '0;
        rem_div   = TBL_DIV;
        ram_we    = 1'b0;
        ram_waddr = clr_addr_reg;
        ram_wdata = IDX_W'(clr_addr_reg);
        ram_raddr = a_reg;

        case (st_reg)
            S_IDLE: begin
                if (cfg_valid) begin
                    case (cfg_index)
                        REG_LEFT: begin
                            left_next  = cfg_data[IDX_W-1:0];
                            phase_next = PH_IDLE;
                        end
                        REG_RIGHT: begin
                            right_next = cfg_data[IDX_W-1:0];
                            phase_next = PH_IDLE;
                        end
                        REG_SIZE: begin
                            size_next  = cfg_data;
                            phase_next = PH_IDLE;
                        end
                        default: ;
                    endcase
                end else if (s_tvalid) begin
                    res_status_next = ST_OK;
                    res_value_next  = '0;
                    res_last_next   = 1'b0;
                    case (s_tuser)
                        MODE_START: begin
                            pos_next  = left_reg;
                            rcnt_next = '0;
                            if (legal) begin
                                phase_next   = PH_SHUF;
                                clr_cnt_next = span1;
                                if (NEED_WRAP) begin
                                    rem_start = 1'b1;
                                    rem_dvd   = DVD_W'(left_reg);
                                    rem_div   = TBL_DIV;
                                    st_next   = S_CLRB;
                                end else begin
                                    clr_addr_next = AW'(left_reg);
                                    st_next       = S_CLEAR;
                                end
                            end else begin
                                phase_next      = PH_IDLE;
                                res_status_next = ST_ILLEGAL;
                                st_next         = S_EMIT;
                            end
                        end
                        MODE_SHUFFLE: begin
                            if (phase_reg != PH_SHUF) begin
                                res_status_next = ST_SEQ;
                                st_next         = S_EMIT;
                            end else if (right_reg != left_reg) begin
                                rem_start = 1'b1;
                                rem_dvd   = s_tdata[WORD_W-1:0];
                                rem_div   = right_reg - left_reg;
                                st_next   = S_MOD;
                            end else begin
                                target_next = right_reg;
                                st_next     = S_ADDR;
                            end
                        end
                        MODE_READ: begin
                            if (phase_reg != PH_READ) begin
                                res_status_next = ST_SEQ;
                                st_next         = S_EMIT;
                            end else begin
                                target_next = left_reg + rcnt_reg[IDX_W-1:0];
                                st_next     = S_RIDX;
                            end
                        end
                        default: begin
                            res_status_next = ST_SEQ;
                            st_next         = S_EMIT;
                        end
                    endcase
                end
            end
            S_CLRB: begin
                if (rem_stat.done) begin
                    clr_addr_next = AW'(rem_val);
                    st_next       = S_CLEAR;
                end
            end
            S_CLEAR: begin
                ram_we        = 1'b1;
                clr_addr_next = (clr_addr_reg == ADDR_LAST) ? '0 : clr_addr_reg + 1'b1;
                clr_cnt_next  = clr_cnt_reg - 1'b1;
                if (clr_cnt_reg == SIZE_W'(1)) begin
                    st_next = S_EMIT;
                end
            end
            S_MOD: begin
                if (rem_stat.done) begin
                    target_next = left_reg + rem_val;
                    st_next     = S_ADDR;
                end
            end
            S_ADDR: begin
                if (NEED_WRAP) begin
                    rem_start = 1'b1;
                    rem_dvd   = DVD_W'(pos_reg);
                    rem_div   = TBL_DIV;
                    st_next   = S_WRPA;
                end else begin
                    a_next  = AW'(pos_reg);
                    b_next  = AW'(target_reg);
                    st_next = S_RDA;
                end
            end
            S_WRPA: begin
                if (rem_stat.done) begin
                    a_next    = AW'(rem_val);
                    rem_start = 1'b1;
                    rem_dvd   = DVD_W'(target_reg);
                    rem_div   = TBL_DIV;
                    st_next   = S_WRPB;
                end
            end
            S_WRPB: begin
                if (rem_stat.done) begin
                    b_next  = AW'(rem_val);
                    st_next = S_RDA;
                end
            end
            S_RDA: begin
                ram_raddr = a_reg;
                st_next   = S_RDB;
            end
            S_RDB: begin
                ram_raddr = b_reg;
                va_next   = ram_rdata;
                st_next   = S_WRA;
            end
            S_WRA: begin
                ram_we    = 1'b1;
                ram_waddr = a_reg;
                ram_wdata = ram_rdata;
                st_next   = S_WRB;
            end
            S_WRB: begin
                ram_we    = 1'b1;
                ram_waddr = b_reg;
                ram_wdata = va_reg;
                if (pos_reg >= right_reg) begin
                    res_last_next = 1'b1;
                    phase_next    = (size_reg == '0) ? PH_DONE : PH_READ;
                end else begin
                    pos_next = pos_reg + 1'b1;
                end
                st_next = S_EMIT;
            end
            S_RIDX: begin
                if (NEED_WRAP) begin
                    rem_start = 1'b1;
                    rem_dvd   = DVD_W'(target_reg);
                    rem_div   = TBL_DIV;
                    st_next   = S_RWRP;
                end else begin
                    a_next  = AW'(target_reg);
                    st_next = S_RDQ;
                end
            end
            S_RWRP: begin
                if (rem_stat.done) begin
                    a_next  = AW'(rem_val);
                    st_next = S_RDQ;
                end
            end
            S_RDQ: begin
                ram_raddr = a_reg;
                st_next   = S_RDD;
            end
            S_RDD: begin
                res_value_next = ram_rdata;
                rcnt_next      = rcnt_inc;
                if (rcnt_inc >= size_reg) begin
                    res_last_next = 1'b1;
                    phase_next    = PH_DONE;
                end
                st_next = S_EMIT;
            end
            S_EMIT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_value_next  = res_value_reg;
                    m_last_next   = res_last_reg;
                    st_next       = S_IDLE;
                end
            end
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= S_IDLE;
            phase_reg   <= PH_IDLE;
            left_reg    <= '0;
            right_reg   <= '0;
            size_reg    <= '0;
            pos_reg     <= '0;
            rcnt_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            st_reg      <= st_next;
            phase_reg   <= phase_next;
            left_reg    <= left_next;
            right_reg   <= right_next;
            size_reg    <= size_next;
            pos_reg     <= pos_next;
            rcnt_reg    <= rcnt_next;
            m_valid_reg <= m_valid_next;
        end
        target_reg     <= target_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        va_reg         <= va_next;
        clr_addr_reg   <= clr_addr_next;
        clr_cnt_reg    <= clr_cnt_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        res_last_reg   <= res_last_next;
        m_status_reg   <= m_status_next;
        m_value_reg    <= m_value_next;
        m_last_reg     <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {{(M_TDATA_W - IDX_W){1'b0}}, m_value_reg};

    `RSM_ASSERT_IMPLY(a_wait_has_unit,
        st_reg == S_MOD || st_reg == S_CLRB || st_reg == S_WRPA || st_reg == S_WRPB ||
        st_reg == S_RWRP,
        rem_stat.busy || rem_stat.done, "sequencer waits on an idle remainder unit")
    `RSM_ASSERT_IMPLY(a_last_only_ok, m_valid_reg && m_last_reg,
        m_status_reg == ST_OK, "last flag on a rejected item")
    `RSM_ASSERT_IMPLY(a_reject_no_value, m_valid_reg && m_status_reg != ST_OK,
        m_value_reg == '0, "sample value on a rejected item")
    `RSM_ASSERT_IMPLY(a_pos_in_range, st_reg == S_IDLE && phase_reg == PH_SHUF,
        pos_reg >= left_reg && pos_reg <= right_reg, "shuffle position outside the range")

endmodule
